/* hw/rtl/sparse_dirichlet_condensation_top_defines.svh */
// assertion macros shared by the condensation block
// no dependencies; included by the controller and the datapath
`ifndef SPARSE_DIRICHLET_CONDENSATION_TOP_DEFINES_SVH
`define SPARSE_DIRICHLET_CONDENSATION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/sdc_pkg.sv */
// types and constants of the condensation block
// no dependencies; used by the interfaces, controller, datapath and top level
package sdc_pkg;

    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 13;
    localparam int ACC_W     = 48;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;

    // item opcodes
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
    localparam logic [OP_W-1:0] OP_SEAL    = 3'd2;
    localparam logic [OP_W-1:0] OP_ENTRY   = 3'd3;
    localparam logic [OP_W-1:0] OP_ROW_END = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG   = 2'd2;

    localparam logic MODE_SYSTEM     = 1'b0;
    localparam logic MODE_CONSTRAINT = 1'b1;

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_RHS    = 1'b1;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ACC_MAX = 48'h7fff_ffff_ffff;
    localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SEAL,
        S_SEAL_END,
        S_EVAL,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    // what the looked-up item turns into
    typedef enum logic [1:0] {
        EV_NONE,
        EV_EMIT,
        EV_MUL
    } t_eval;

    typedef struct packed {
        logic capture;
        logic row_restart;
        logic sweep_rst;
        logic clear_wr;
        logic seal_rd;
        logic mark_wr;
        logic eval;
        logic mul;
        logic acc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_last;
        logic            out_free;
        t_eval           ev;
    } t_status;

endpackage

/* hw/rtl/sdc_if.sv */
// valid/ready channels of the condensation block: items in, results out, register writes
// depends on sdc_pkg
interface sdc_in_if;
    logic                              valid;
    logic                              ready;
    logic [sdc_pkg::OP_W-1:0]          op;
    logic                              block;
    logic [sdc_pkg::IDX_W-1:0]         dof_index;
    logic [sdc_pkg::IDX_W-1:0]         row_index;
    logic signed [sdc_pkg::VAL_W-1:0]  value;

    modport source (output valid, op, block, dof_index, row_index, value, input ready);
    modport sink   (input valid, op, block, dof_index, row_index, value, output ready);
endinterface

interface sdc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [sdc_pkg::IDX_W-1:0]         out_row;
    logic [sdc_pkg::IDX_W-1:0]         out_col;
    logic signed [sdc_pkg::VAL_W-1:0]  out_value;
    logic                              saturated;

    modport source (output valid, kind, out_row, out_col, out_value, saturated, input ready);
    modport sink   (input valid, kind, out_row, out_col, out_value, saturated, output ready);
endinterface

interface sdc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sdc_pkg::CFG_IDX_W-1:0]     index;
    logic [sdc_pkg::VAL_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/sdc_ctrl.sv */
// sequencer of the condensation block: sweeps, lookups, multiply-accumulate, result hand-off
// depends on sdc_pkg and the assertion macro header
`include "sparse_dirichlet_condensation_top_defines.svh"

module sdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sdc_pkg::t_status i_status,
    output sdc_pkg::t_cmd    o_cmd
);

    sdc_pkg::t_state r_state;
    sdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdc_pkg::S_CLEAR: begin
                if (i_status.sweep_last) n_state = sdc_pkg::S_IDLE;
            end
            sdc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sdc_pkg::S_DISPATCH;
            end
            sdc_pkg::S_DISPATCH: begin
                case (i_status.op)
                    sdc_pkg::OP_CLEAR:   n_state = sdc_pkg::S_CLEAR;
                    sdc_pkg::OP_SEAL:    n_state = sdc_pkg::S_SEAL;
                    sdc_pkg::OP_ENTRY:   n_state = sdc_pkg::S_EVAL;
                    sdc_pkg::OP_ROW_END: n_state = sdc_pkg::S_EVAL;
                    default:             n_state = sdc_pkg::S_IDLE;
                endcase
            end
            sdc_pkg::S_SEAL: begin
                if (i_status.sweep_last) n_state = sdc_pkg::S_SEAL_END;
            end
            sdc_pkg::S_SEAL_END: begin
                n_state = sdc_pkg::S_IDLE;
            end
            sdc_pkg::S_EVAL: begin
                unique case (i_status.ev)
                    sdc_pkg::EV_EMIT: n_state = sdc_pkg::S_EMIT;
                    sdc_pkg::EV_MUL:  n_state = sdc_pkg::S_MUL;
                    default:          n_state = sdc_pkg::S_IDLE;
                endcase
            end
            sdc_pkg::S_MUL: begin
                n_state = sdc_pkg::S_ACC;
            end
            sdc_pkg::S_ACC: begin
                n_state = sdc_pkg::S_IDLE;
            end
            sdc_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = sdc_pkg::S_IDLE;
            end
            default: begin
                n_state = sdc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sdc_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            sdc_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            sdc_pkg::S_DISPATCH: begin
                case (i_status.op)
                    sdc_pkg::OP_CLEAR: begin
                        o_cmd.row_restart = 1'b1;
                        o_cmd.sweep_rst   = 1'b1;
                    end
                    sdc_pkg::OP_SEAL: begin
                        o_cmd.row_restart = 1'b1;
                        o_cmd.sweep_rst   = 1'b1;
                    end
                    sdc_pkg::OP_MARK: begin
                        o_cmd.mark_wr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            sdc_pkg::S_SEAL: begin
                o_cmd.seal_rd = 1'b1;
            end
            sdc_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            sdc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            sdc_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
            end
            sdc_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    `SDC_ASSERT_NEXT(a_capture_dispatch, i_clk, i_rst_n, o_cmd.capture, r_state == sdc_pkg::S_DISPATCH, "captured item not dispatched")
    `SDC_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_status.out_free, "result loaded over a waiting result")
    `SDC_ASSERT_NEXT(a_seal_end_idle, i_clk, i_rst_n, r_state == sdc_pkg::S_SEAL_END, r_state == sdc_pkg::S_IDLE, "seal did not return to idle")

endmodule

/* hw/rtl/sdc_datapath.sv */
// datapath of the condensation block: marker, count and prescribed-value memories,
// row accumulator, multiplier, result staging and output register; depends on sdc_pkg
`include "sparse_dirichlet_condensation_top_defines.svh"

module sdc_datapath #(
    parameter int NUM_DOFS = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sdc_pkg::t_cmd                         i_cmd,
    output sdc_pkg::t_status                      o_status,
    input  logic [sdc_pkg::OP_W-1:0]              i_op,
    input  logic                                  i_block,
    input  logic [sdc_pkg::IDX_W-1:0]             i_dof_index,
    input  logic [sdc_pkg::IDX_W-1:0]             i_row_index,
    input  logic signed [sdc_pkg::VAL_W-1:0]      i_value,
    input  logic                                  i_cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sdc_pkg::VAL_W-1:0]             i_cfg_data,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_kind,
    output logic [sdc_pkg::IDX_W-1:0]             o_out_row,
    output logic [sdc_pkg::IDX_W-1:0]             o_out_col,
    output logic signed [sdc_pkg::VAL_W-1:0]      o_out_value,
    output logic                                  o_saturated
);

    localparam int AW = $clog2(NUM_DOFS);
    localparam logic [16:0]   N_WIDE = 17'(NUM_DOFS);
    localparam logic [AW-1:0] LAST   = AW'(NUM_DOFS - 1);

    function automatic logic fits32(input logic [48:0] x);
        return x[48:31] == {18{x[31]}};
    endfunction

    function automatic logic [31:0] sat32(input logic [48:0] x);
        if (fits32(x)) return x[31:0];
        return x[48] ? sdc_pkg::VAL_MIN : sdc_pkg::VAL_MAX;
    endfunction

    // captured item
    logic [sdc_pkg::OP_W-1:0]         r_op;
    logic                             r_block;
    logic [sdc_pkg::IDX_W-1:0]        r_dof;
    logic [sdc_pkg::IDX_W-1:0]        r_row;
    logic signed [sdc_pkg::VAL_W-1:0] r_val;

    // registers
    logic                             r_mode;
    logic [sdc_pkg::IDX_W-1:0]        r_offset;
    logic [sdc_pkg::VAL_W-1:0]        r_diag;

    // row state
    logic [sdc_pkg::CNT_W-1:0]        r_crow;
    logic [sdc_pkg::ACC_W-1:0]        r_acc;
    logic                             r_clamped;

    // sweeps
    logic [AW-1:0]                    r_sweep;
    logic                             r_seal_pend;
    logic [AW-1:0]                    r_seal_waddr;
    logic [sdc_pkg::CNT_W-1:0]        r_run;

    // memories and their read registers
    logic                             mem_mark [NUM_DOFS];
    logic [sdc_pkg::CNT_W-1:0]        mem_cnt  [NUM_DOFS];
    logic [sdc_pkg::VAL_W-1:0]        mem_pres [NUM_DOFS];
    logic                             r_mark_a;
    logic                             r_mark_b;
    logic [sdc_pkg::CNT_W-1:0]        r_cnt_rd;
    logic signed [sdc_pkg::VAL_W-1:0] r_pres_rd;

    logic signed [63:0]               r_prod;

    // staged result and output register
    logic                             r_st_kind;
    logic [sdc_pkg::IDX_W-1:0]        r_st_row;
    logic [sdc_pkg::IDX_W-1:0]        r_st_col;
    logic [sdc_pkg::VAL_W-1:0]        r_st_value;
    logic                             r_st_sat;
    logic                             r_out_valid;
    logic                             r_out_kind;
    logic [sdc_pkg::IDX_W-1:0]        r_out_row;
    logic [sdc_pkg::IDX_W-1:0]        r_out_col;
    logic [sdc_pkg::VAL_W-1:0]        r_out_value;
    logic                             r_out_sat;

    logic [16:0]               dof_w;
    logic [16:0]               row_w;
    logic [16:0]               mark_w;
    logic [sdc_pkg::CNT_W-1:0] mark_sum;
    logic                      dof_ok;
    logic                      row_ok;
    logic                      mark_ok;
    logic [AW-1:0]             dof_addr;
    logic [AW-1:0]             row_addr;
    logic [AW-1:0]             mark_addr;
    logic [AW-1:0]             rd_b_addr;
    logic                      sys;
    logic                      sweep_last;
    logic                      row_skip;
    sdc_pkg::t_eval            ev;
    logic [sdc_pkg::IDX_W-1:0] col;
    logic [sdc_pkg::IDX_W-1:0] crow;
    logic                      diag_hit;
    logic [48:0]               ent_sum;
    logic [48:0]               rhs_sum;
    logic [48:0]               res_sum;
    logic [49:0]               acc_new;
    logic                      acc_fits;
    logic [sdc_pkg::CNT_W-1:0] run_next;
    logic                      out_free;

    always_comb begin
        dof_w     = {5'd0, r_dof};
        row_w     = {5'd0, r_row};
        mark_sum  = {1'b0, r_dof} + (r_block ? {1'b0, r_offset} : 13'd0);
        mark_w    = {4'd0, mark_sum};
        dof_ok    = dof_w < N_WIDE;
        row_ok    = row_w < N_WIDE;
        mark_ok   = mark_w < N_WIDE;
        dof_addr  = dof_w[AW-1:0];
        row_addr  = row_w[AW-1:0];
        mark_addr = mark_w[AW-1:0];
        rd_b_addr = i_cmd.seal_rd ? r_sweep : dof_addr;
        sys        = r_mode == sdc_pkg::MODE_SYSTEM;
        sweep_last = r_sweep == LAST;
        run_next   = r_run + {12'd0, r_mark_b};
        out_free   = !r_out_valid || i_out_ready;
    end

    // classify the looked-up item
    always_comb begin
        ev       = sdc_pkg::EV_NONE;
        row_skip = 1'b0;
        case (r_op)
            sdc_pkg::OP_ENTRY: begin
                if (dof_ok && !(sys && (!row_ok || r_mark_a))) begin
                    ev = r_mark_b ? sdc_pkg::EV_MUL : sdc_pkg::EV_EMIT;
                end
            end
            sdc_pkg::OP_ROW_END: begin
                if (!sys) begin
                    ev = sdc_pkg::EV_EMIT;
                end else if (row_ok) begin
                    if (r_mark_a) row_skip = 1'b1;
                    else          ev = sdc_pkg::EV_EMIT;
                end
            end
            default: begin
            end
        endcase
    end

    // result arithmetic
    always_comb begin
        col      = r_dof - r_cnt_rd[sdc_pkg::IDX_W-1:0];
        crow     = r_crow[sdc_pkg::IDX_W-1:0];
        diag_hit = sys && (col == crow);
        ent_sum  = {{17{r_val[31]}}, r_val}
                 + (diag_hit ? {{17{r_diag[31]}}, r_diag} : 49'd0);
        rhs_sum  = {r_acc[47], r_acc} + (sys ? {{17{r_val[31]}}, r_val} : 49'd0);
        res_sum  = (r_op == sdc_pkg::OP_ROW_END) ? rhs_sum : ent_sum;
        // acc - round(prod / 2^16), rounding folded into the carry
        acc_new  = {{2{r_acc[47]}}, r_acc}
                 + {{2{~r_prod[63]}}, ~r_prod[63:16]}
                 + {49'd0, ~r_prod[15]};
        acc_fits = acc_new[49:47] == {3{acc_new[47]}};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_block <= i_block;
            r_dof   <= i_dof_index;
            r_row   <= i_row_index;
            r_val   <= i_value;
        end
        if (i_cmd.mul) begin
            r_prod <= r_val * r_pres_rd;
        end
        if (i_cmd.eval && ev == sdc_pkg::EV_EMIT) begin
            r_st_kind  <= (r_op == sdc_pkg::OP_ROW_END) ? sdc_pkg::KIND_RHS
                                                        : sdc_pkg::KIND_MATRIX;
            r_st_row   <= crow;
            r_st_col   <= (r_op == sdc_pkg::OP_ROW_END) ? '0 : col;
            r_st_value <= sat32(res_sum);
            r_st_sat   <= !fits32(res_sum)
                          || (r_op == sdc_pkg::OP_ROW_END && r_clamped);
        end
        if (i_cmd.emit) begin
            r_out_kind  <= r_st_kind;
            r_out_row   <= r_st_row;
            r_out_col   <= r_st_col;
            r_out_value <= r_st_value;
            r_out_sat   <= r_st_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sdc_pkg::MODE_SYSTEM;
            r_offset    <= '0;
            r_diag      <= '0;
            r_crow      <= '0;
            r_acc       <= '0;
            r_clamped   <= 1'b0;
            r_sweep     <= '0;
            r_seal_pend <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdc_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                    sdc_pkg::CFG_OFFSET: r_offset <= i_cfg_data[sdc_pkg::IDX_W-1:0];
                    sdc_pkg::CFG_DIAG:   r_diag   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.sweep_rst) begin
                r_sweep <= '0;
                r_run   <= '0;
            end else if (i_cmd.clear_wr || i_cmd.seal_rd) begin
                r_sweep <= sweep_last ? '0 : r_sweep + AW'(1);
            end
            r_seal_pend  <= i_cmd.seal_rd;
            r_seal_waddr <= r_sweep;
            if (r_seal_pend) begin
                r_run <= run_next;
            end

            if (i_cmd.row_restart) begin
                r_crow    <= '0;
                r_acc     <= '0;
                r_clamped <= 1'b0;
            end else if (i_cmd.eval && (row_skip
                         || (ev == sdc_pkg::EV_EMIT && r_op == sdc_pkg::OP_ROW_END))) begin
                if (!row_skip) r_crow <= r_crow + 13'd1;
                r_acc     <= '0;
                r_clamped <= 1'b0;
            end else if (i_cmd.acc) begin
                if (acc_fits) begin
                    r_acc <= acc_new[sdc_pkg::ACC_W-1:0];
                end else begin
                    r_acc     <= acc_new[49] ? sdc_pkg::ACC_MIN : sdc_pkg::ACC_MAX;
                    r_clamped <= 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // marker memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            mem_mark[r_sweep] <= 1'b0;
        end else if (i_cmd.mark_wr && mark_ok) begin
            mem_mark[mark_addr] <= 1'b1;
        end
        r_mark_a <= mem_mark[row_addr];
        r_mark_b <= mem_mark[rd_b_addr];
    end

    // running count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            mem_cnt[r_sweep] <= '0;
        end else if (r_seal_pend) begin
            mem_cnt[r_seal_waddr] <= run_next;
        end
        r_cnt_rd <= mem_cnt[dof_addr];
    end

    // prescribed value memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_wr && mark_ok) begin
            mem_pres[mark_addr] <= r_val;
        end
        r_pres_rd <= mem_pres[dof_addr];
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.sweep_last = sweep_last;
        o_status.out_free   = out_free;
        o_status.ev         = ev;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_saturated = r_out_sat;

    `SDC_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_out_valid, "loaded result not presented")
    `SDC_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, i_cmd.row_restart, r_crow == '0 && r_acc == '0 && !r_clamped, "row state not restarted")
    `SDC_ASSERT_NEXT(a_sweep_wrap, i_clk, i_rst_n, (i_cmd.clear_wr || i_cmd.seal_rd) && sweep_last, r_sweep == '0, "sweep address did not wrap")

endmodule

/* hw/rtl/sparse_dirichlet_condensation_top.sv */
// top level of the sparse Dirichlet condensation block
// depends on sdc_pkg, the channel interfaces, sdc_ctrl and sdc_datapath
//
// Removes constrained dofs from a sparse system that streams in one nonzero per item.
// Items: clear markers, mark a dof with its prescribed value, seal (build the running
// counts of constrained dofs), nonzero entry, row end. Results leave through a registered
// output, so an item is accepted while an earlier result still waits. Items are handled
// one at a time by a controller that walks a datapath of memory tables; every lookup
// goes through the registered reads of the marker, count and prescribed-value memories.
// A mark writes the marker and prescribed value at dispatch; a free-column entry or row end
// is dispatched, evaluated and emitted (plus any output stall); a constrained-column entry
// is dispatched and evaluated, then takes a registered 32x32 multiply and the saturating
// accumulate; dropped entries end at evaluation, unknown ops at dispatch. Clear and seal
// sweep the dof memories one entry per cycle. After reset a pass clears the marker and
// count memories with the item input not ready; register writes are always taken.
// Registers must be written only while no item is in flight; the block does not enforce it.
module sparse_dirichlet_condensation_top #(
    parameter int NUM_DOFS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdc_in_if.sink    i_in,
    sdc_out_if.source o_out,
    sdc_cfg_if.sink   i_cfg
);

    sdc_pkg::t_cmd    cmd;
    sdc_pkg::t_status status;
    logic             in_ready;

    // register port never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    sdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdc_datapath #(
        .NUM_DOFS (NUM_DOFS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_in.op),
        .i_block     (i_in.block),
        .i_dof_index (i_in.dof_index),
        .i_row_index (i_in.row_index),
        .i_value     (i_in.value),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_kind      (o_out.kind),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_out_value (o_out.out_value),
        .o_saturated (o_out.saturated)
    );

endmodule
